FILE: sv/hbc_pkg.sv
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared types, codes and widths of the hashed block buffer cache.
// ----------------------------------------------------------------------------
package hbc_pkg;

    // Default table geometry.
    localparam int DEF_NUM_BUFFERS = 32;
    localparam int DEF_NUM_BUCKETS = 13;

    // Fixed field widths.
    localparam int DEV_W    = 8;
    localparam int BLK_W    = 32;
    localparam int HDL_W    = 5;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 8;
    localparam int BKT_W    = 4;
    localparam int STAMP_W  = 32;
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Request kinds.
    typedef enum logic [1:0] {
        K_GET     = 2'd0,
        K_RELEASE = 2'd1,
        K_PIN     = 2'd2,
        K_UNPIN   = 2'd3
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_NOBUF = 2'd1,
        STS_UNDER = 2'd2,
        STS_SAT   = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_DECIDE,
        S_HREAD,
        S_HCALC,
        S_RESULT
    } t_state;

    // One tag table entry as held in the RAM.
    typedef struct packed {
        logic [DEV_W-1:0]   device;
        logic [BLK_W-1:0]   block;
        logic [CNT_W-1:0]   count;
        logic               filled;
        logic [BKT_W-1:0]   bucket;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One result item, entry index in the lowest bits.
    typedef struct packed {
        logic [CNT_W-1:0] ref_count;
        t_status          status;
        logic             need_fill;
        logic [IDX_W-1:0] entry_index;
    } t_result;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    // Which candidates the scan unit has found.
    typedef struct packed {
        logic hit;
        logic own;
        logic stl;
    } t_scan_flags;

endpackage

FILE: sv/hbc_ram.sv
// ----------------------------------------------------------------------------
// hbc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/hbc_mod.sv
// ----------------------------------------------------------------------------
// hbc_mod
// Block number modulo the bucket count, four bits per cycle, MSB first.
// ----------------------------------------------------------------------------
module hbc_mod #(
    parameter int NUM_BUCKETS = hbc_pkg::DEF_NUM_BUCKETS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hbc_pkg::BLK_W-1:0]  i_value,
    output logic                       o_busy,
    output logic [hbc_pkg::BKT_W-1:0]  o_rem
);
    import hbc_pkg::*;

    localparam int NIB_N = BLK_W / 4;
    localparam int CW    = $clog2(NIB_N);
    localparam logic [7:0] M1 = 8'(NUM_BUCKETS);
    localparam logic [7:0] M2 = 8'(NUM_BUCKETS * 2);
    localparam logic [7:0] M4 = 8'(NUM_BUCKETS * 4);
    localparam logic [7:0] M8 = 8'(NUM_BUCKETS * 8);
    localparam logic [CW-1:0] LAST = CW'(NIB_N - 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [BLK_W-1:0] r_val;
    logic [BKT_W-1:0] r_rem;
    logic [7:0]       t0, t1, t2, t3, t4;

    // Remainder step: the shifted value stays below 16 times the modulus,
    // so four conditional subtractions bring it back below the modulus.
    always_comb begin
        t0 = {r_rem, r_val[BLK_W-1 -: 4]};
        t1 = (t0 >= M8) ? 8'(t0 - M8) : t0;
        t2 = (t1 >= M4) ? 8'(t1 - M4) : t1;
        t3 = (t2 >= M2) ? 8'(t2 - M2) : t2;
        t4 = (t3 >= M1) ? 8'(t3 - M1) : t3;
    end

    // Busy flag and nibble counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= CW'(r_cnt + 1'b1);
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Value shifter and running remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[BLK_W-5:0], 4'b0};
            r_rem <= t4[BKT_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

FILE: sv/hbc_scan.sv
// ----------------------------------------------------------------------------
// hbc_scan
// Candidate tracker: looks at one table entry per step and keeps the newest
// match, the oldest free entry of the own bucket and the steal candidate.
// ----------------------------------------------------------------------------
module hbc_scan #(
    parameter int NUM_BUFFERS = hbc_pkg::DEF_NUM_BUFFERS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hbc_pkg::t_scan_ctl                   i_ctl,
    input  logic [$clog2(NUM_BUFFERS)-1:0]       i_idx,
    input  hbc_pkg::t_entry                      i_entry,
    input  logic [hbc_pkg::DEV_W-1:0]            i_dev,
    input  logic [hbc_pkg::BLK_W-1:0]            i_blk,
    input  logic [hbc_pkg::BKT_W-1:0]            i_bkt,
    output hbc_pkg::t_scan_flags                 o_flags,
    output logic [$clog2(NUM_BUFFERS)-1:0]       o_hit_idx,
    output logic [hbc_pkg::STAMP_W-1:0]          o_hit_stamp,
    output logic [hbc_pkg::CNT_W-1:0]            o_hit_count,
    output logic                                 o_hit_filled,
    output logic [$clog2(NUM_BUFFERS)-1:0]       o_own_idx,
    output logic [hbc_pkg::STAMP_W-1:0]          o_own_stamp,
    output logic [$clog2(NUM_BUFFERS)-1:0]       o_stl_idx
);
    import hbc_pkg::*;

    localparam int AW = $clog2(NUM_BUFFERS);

    t_scan_flags        r_flags;
    logic [AW-1:0]      r_hit_idx, r_own_idx, r_stl_idx;
    logic [STAMP_W-1:0] r_hit_stamp, r_own_stamp, r_stl_stamp;
    logic [CNT_W-1:0]   r_hit_count;
    logic               r_hit_filled;
    logic [BKT_W-1:0]   r_stl_bkt;
    logic               is_free, is_match, take_hit, take_own, take_stl;

    // Compare the entry under view against the current candidates. Ties go
    // to the lower index, since entries arrive in ascending order.
    always_comb begin
        is_free  = (i_entry.count == '0);
        is_match = (i_entry.bucket == i_bkt) && (i_entry.device == i_dev) &&
                   (i_entry.block == i_blk);
        take_hit = i_ctl.step && is_match &&
                   (!r_flags.hit || (i_entry.stamp > r_hit_stamp));
        take_own = i_ctl.step && is_free && (i_entry.bucket == i_bkt) &&
                   (!r_flags.own || (i_entry.stamp < r_own_stamp));
        take_stl = i_ctl.step && is_free && (i_entry.bucket != i_bkt) &&
                   (!r_flags.stl || (i_entry.bucket < r_stl_bkt) ||
                    ((i_entry.bucket == r_stl_bkt) && (i_entry.stamp < r_stl_stamp)));
    end

    // Found flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_flags <= '0;
        end else begin
            if (take_hit) r_flags.hit <= 1'b1;
            if (take_own) r_flags.own <= 1'b1;
            if (take_stl) r_flags.stl <= 1'b1;
        end
    end

    // Candidate payload.
    always_ff @(posedge i_clk) begin
        if (take_hit) begin
            r_hit_idx    <= i_idx;
            r_hit_stamp  <= i_entry.stamp;
            r_hit_count  <= i_entry.count;
            r_hit_filled <= i_entry.filled;
        end
        if (take_own) begin
            r_own_idx   <= i_idx;
            r_own_stamp <= i_entry.stamp;
        end
        if (take_stl) begin
            r_stl_idx   <= i_idx;
            r_stl_stamp <= i_entry.stamp;
            r_stl_bkt   <= i_entry.bucket;
        end
    end

    assign o_flags      = r_flags;
    assign o_hit_idx    = r_hit_idx;
    assign o_hit_stamp  = r_hit_stamp;
    assign o_hit_count  = r_hit_count;
    assign o_hit_filled = r_hit_filled;
    assign o_own_idx    = r_own_idx;
    assign o_own_stamp  = r_own_stamp;
    assign o_stl_idx    = r_stl_idx;

endmodule

FILE: sv/hashed_block_buffer_cache.sv
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// Tag table of a block buffer cache with hashed buckets, reference counts
// and stealing of free entries from other buckets.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the slave stream (s_t*), one item per request;
// s_tuser carries the kind (get, release, pin, unpin). Each request yields
// exactly one result item on the master stream (m_t*).
// A get first reduces the block number modulo the bucket count, four bits a
// cycle, then walks the whole tag RAM once, one entry a cycle through its read
// port, then decides and writes the chosen entry back. Release, pin and unpin
// read a single entry and, when the handle is in range, rewrite it.
// The RAM read port and the sequencer handle one request at a time, so
// s_tready is high only while the block is idle; a request may be taken
// while the previous result still waits in the output register.
// If the receiver stalls, the result holds in the output register and a
// finished request waits before being reported.
// Reset is synchronous and active low; it clears the entry valid bits, so
// every entry reads back as its reset value until first written, and the
// stamp counter returns to NUM_BUFFERS. No clearing pass is needed.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache #(
    parameter int NUM_BUFFERS = hbc_pkg::DEF_NUM_BUFFERS,
    parameter int NUM_BUCKETS = hbc_pkg::DEF_NUM_BUCKETS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // device[7:0], block_number[39:8], buffer_handle[44:40], zero[47:45]
    input  logic [hbc_pkg::S_DATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [hbc_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // entry_index[4:0], need_fill[5], status[7:6], ref_count[15:8]
    output logic [hbc_pkg::M_DATA_W-1:0]  m_tdata
);
    import hbc_pkg::*;

    localparam int AW = $clog2(NUM_BUFFERS);
    localparam logic [AW:0] NB_C = (AW+1)'(NUM_BUFFERS);

    t_state             r_state, n_state;
    t_kind              r_kind;
    logic [DEV_W-1:0]   r_dev;
    logic [BLK_W-1:0]   r_blk;
    logic [HDL_W-1:0]   r_hdl;
    logic [AW:0]        r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pidx;
    logic [NUM_BUFFERS-1:0] r_valid;
    logic               r_rd_vld;
    logic [STAMP_W-1:0] r_stamp_ctr, n_stamp_ctr;
    t_result            r_res, n_res;
    t_result            r_out, n_out;
    logic               r_out_vld, n_out_vld;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    t_entry             ram_wdata, ram_rdata, rd_entry;

    logic               mod_start, mod_busy;
    logic [BKT_W-1:0]   bkt;

    t_scan_ctl          scan_ctl;
    t_scan_flags        scan_flags;
    logic [AW-1:0]      hit_idx, own_idx, stl_idx;
    logic [STAMP_W-1:0] hit_stamp, own_stamp;
    logic [CNT_W-1:0]   hit_count;
    logic               hit_filled;

    logic [AW+HDL_W-1:0] hdl_ext;
    logic [AW-1:0]      hdl_addr;
    logic               hdl_ok;
    logic [CNT_W-1:0]   new_count;
    logic               out_free;

    // Handle to table address, and its range check.
    assign hdl_ext  = {{AW{1'b0}}, r_hdl};
    assign hdl_addr = hdl_ext[AW-1:0];
    assign hdl_ok   = (32'(r_hdl) < 32'(NUM_BUFFERS));
    assign out_free = !r_out_vld || m_tready;

    // Entry under view: a never-written entry reads as its reset value.
    always_comb begin
        if (r_rd_vld) begin
            rd_entry = ram_rdata;
        end else begin
            rd_entry       = '0;
            rd_entry.stamp = STAMP_W'(r_pidx);
        end
    end

    // Tag table storage.
    hbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BUFFERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Bucket of the requested block.
    hbc_mod #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (s_tdata[DEV_W +: BLK_W]),
        .o_busy  (mod_busy),
        .o_rem   (bkt)
    );

    // Candidate tracking during the table walk.
    hbc_scan #(
        .NUM_BUFFERS (NUM_BUFFERS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_idx        (r_pidx),
        .i_entry      (rd_entry),
        .i_dev        (r_dev),
        .i_blk        (r_blk),
        .i_bkt        (bkt),
        .o_flags      (scan_flags),
        .o_hit_idx    (hit_idx),
        .o_hit_stamp  (hit_stamp),
        .o_hit_count  (hit_count),
        .o_hit_filled (hit_filled),
        .o_own_idx    (own_idx),
        .o_own_stamp  (own_stamp),
        .o_stl_idx    (stl_idx)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_state = (t_kind'(s_tuser) == K_GET) ? S_MOD : S_HREAD;
                end
            end
            S_MOD: begin
                if (!mod_busy) n_state = S_SCAN;
            end
            S_SCAN: begin
                if ((r_idx == NB_C) && !r_pend) n_state = S_DECIDE;
            end
            S_DECIDE: n_state = S_RESULT;
            S_HREAD:  n_state = S_HCALC;
            S_HCALC:  n_state = S_RESULT;
            S_RESULT: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs and datapath control.
    always_comb begin
        s_tready    = 1'b0;
        mod_start   = 1'b0;
        scan_ctl    = '0;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_stamp_ctr = r_stamp_ctr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_vld   = r_out_vld && !m_tready;
        ram_we      = 1'b0;
        ram_waddr   = hdl_addr;
        ram_raddr   = r_idx[AW-1:0];
        ram_wdata   = rd_entry;
        new_count   = '0;
        case (r_state)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mod_start      = (t_kind'(s_tuser) == K_GET);
                    scan_ctl.clear = 1'b1;
                    n_idx          = '0;
                end
            end
            S_SCAN: begin
                scan_ctl.step = r_pend;
                if (r_idx != NB_C) begin
                    n_idx  = (AW+1)'(r_idx + 1'b1);
                    n_pend = 1'b1;
                end
            end
            S_DECIDE: begin
                ram_wdata.device = r_dev;
                ram_wdata.block  = r_blk;
                ram_wdata.filled = 1'b1;
                ram_wdata.bucket = bkt;
                if (scan_flags.hit) begin
                    // Hit: one more reference, saturating.
                    new_count = (hit_count == CNT_MAX) ? hit_count :
                                CNT_W'(hit_count + 1'b1);
                    ram_we            = 1'b1;
                    ram_waddr         = hit_idx;
                    ram_wdata.count   = new_count;
                    ram_wdata.stamp   = hit_stamp;
                    n_res.entry_index = IDX_W'({{IDX_W{1'b0}}, hit_idx});
                    n_res.need_fill   = !hit_filled;
                    n_res.status      = (hit_count == CNT_MAX) ? STS_SAT : STS_OK;
                    n_res.ref_count   = new_count;
                end else if (scan_flags.own || scan_flags.stl) begin
                    // Reuse in the own bucket keeps the stamp; a steal
                    // takes a fresh one.
                    ram_we          = 1'b1;
                    ram_wdata.count = CNT_W'(1);
                    if (scan_flags.own) begin
                        ram_waddr       = own_idx;
                        ram_wdata.stamp = own_stamp;
                    end else begin
                        ram_waddr       = stl_idx;
                        ram_wdata.stamp = r_stamp_ctr;
                        n_stamp_ctr     = STAMP_W'(r_stamp_ctr + 1'b1);
                    end
                    n_res.entry_index = IDX_W'({{IDX_W{1'b0}}, ram_waddr});
                    n_res.need_fill   = 1'b1;
                    n_res.status      = STS_OK;
                    n_res.ref_count   = CNT_W'(1);
                end else begin
                    n_res.entry_index = '0;
                    n_res.need_fill   = 1'b0;
                    n_res.status      = STS_NOBUF;
                    n_res.ref_count   = '0;
                end
            end
            S_HREAD: begin
                ram_raddr = hdl_addr;
            end
            S_HCALC: begin
                n_res.entry_index = r_hdl;
                n_res.need_fill   = 1'b0;
                if (!hdl_ok) begin
                    n_res.status    = STS_NOBUF;
                    n_res.ref_count = '0;
                end else begin
                    if (r_kind == K_PIN) begin
                        if (rd_entry.count == CNT_MAX) begin
                            new_count    = rd_entry.count;
                            n_res.status = STS_SAT;
                        end else begin
                            new_count    = CNT_W'(rd_entry.count + 1'b1);
                            n_res.status = STS_OK;
                        end
                    end else begin
                        if (rd_entry.count == '0) begin
                            new_count    = rd_entry.count;
                            n_res.status = STS_UNDER;
                        end else begin
                            new_count    = CNT_W'(rd_entry.count - 1'b1);
                            n_res.status = STS_OK;
                        end
                    end
                    ram_we          = 1'b1;
                    ram_wdata.count = new_count;
                    n_res.ref_count = new_count;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_idx       <= '0;
            r_valid     <= '0;
            r_stamp_ctr <= STAMP_W'(NUM_BUFFERS);
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_idx       <= n_idx;
            r_stamp_ctr <= n_stamp_ctr;
            r_out_vld   <= n_out_vld;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers: request, read tracking and results.
    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_kind <= t_kind'(s_tuser);
            r_dev  <= s_tdata[0 +: DEV_W];
            r_blk  <= s_tdata[DEV_W +: BLK_W];
            r_hdl  <= s_tdata[DEV_W + BLK_W +: HDL_W];
        end
        r_pidx   <= ram_raddr;
        r_rd_vld <= r_valid[ram_raddr];
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {r_out.ref_count, r_out.status, r_out.need_fill, r_out.entry_index};

endmodule

FILE: sv/hbc_chk.sv
// ----------------------------------------------------------------------------
// hbc_chk
// Port-level checks of the hashed block buffer cache, bound to the top level.
// ----------------------------------------------------------------------------
module hbc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hbc_pkg::M_DATA_W-1:0]  m_tdata
);
    import hbc_pkg::*;

    // A stalled result item holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // No result item is shown straight after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result item valid after reset");

    // A missing buffer reports no fill and a zero count.
    a_nobuf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[7:6] == STS_NOBUF) |-> !m_tdata[5] && (m_tdata[15:8] == '0))
        else $error("no-buffer result with fill or count");

    // Underflow leaves the count at zero and saturation at its maximum.
    a_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((m_tdata[7:6] != STS_UNDER) || (m_tdata[15:8] == '0)) &&
                     ((m_tdata[7:6] != STS_SAT) || (m_tdata[15:8] == CNT_MAX)))
        else $error("count out of line with status");

endmodule

bind hashed_block_buffer_cache hbc_chk u_hbc_chk (.*);

FILE: verif/hashed_block_buffer_cache_tb.sv
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_tb
// Self-checking testbench for the hashed block buffer cache. A scoreboard
// keeps its own copy of the tag table, predicts one result item for every
// request item taken by the block and compares each result field by field.
// Stimulus is a directed opening, a saturation run on one entry, a fill-up
// until no buffer is free, a back-pressure burst and a long random churn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_block_buffer_cache_tb;
    import hbc_pkg::*;

    // Scoreboard holding the predicted tag table and the expected result items.
    class cache_scoreboard;
        localparam int NBUF = DEF_NUM_BUFFERS;
        localparam int NBKT = DEF_NUM_BUCKETS;

        logic [DEV_W-1:0]   dev_tag [NBUF];
        logic [BLK_W-1:0]   blk_tag [NBUF];
        logic [CNT_W-1:0]   refs    [NBUF];
        bit                 filled  [NBUF];
        logic [BKT_W-1:0]   bucket  [NBUF];
        logic [STAMP_W-1:0] stamp   [NBUF];
        logic [STAMP_W-1:0] next_stamp;

        t_result expected_q[$];
        int      errors;
        int      n_checked;
        int      n_hits;
        int      n_steals;
        int      n_status[4];
        int      last_index;

        function new();
            for (int k = 0; k < NBUF; k++) begin
                dev_tag[k] = '0;
                blk_tag[k] = '0;
                refs[k]    = '0;
                filled[k]  = 1'b0;
                bucket[k]  = '0;
                stamp[k]   = STAMP_W'(k);
            end
            next_stamp = STAMP_W'(NBUF);
            errors     = 0;
            n_checked  = 0;
            n_hits     = 0;
            n_steals   = 0;
            last_index = 0;
            for (int s = 0; s < 4; s++) n_status[s] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Random entry that currently holds at least one reference, or -1.
        function int pick_held();
            int held[$];
            for (int k = 0; k < NBUF; k++)
                if (refs[k] != 0) held.push_back(k);
            if (held.size() == 0) return -1;
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

        // Free entry with the smallest stamp in bucket b; ties go to the lowest index.
        function int oldest_free(int unsigned b);
            int best;
            best = -1;
            for (int k = 0; k < NBUF; k++) begin
                if (bucket[k] != b || refs[k] != 0) continue;
                if (best < 0 || stamp[k] < stamp[best]) best = k;
            end
            return best;
        endfunction

        function t_result lookup_block(logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk);
            t_result     r;
            int unsigned id;
            int          hit;
            int          e;
            r   = '0;
            id  = blk % NBKT;
            hit = -1;
            // The newest matching entry of the bucket wins.
            for (int k = 0; k < NBUF; k++) begin
                if (bucket[k] == id && dev_tag[k] == dev && blk_tag[k] == blk)
                    if (hit < 0 || stamp[k] > stamp[hit]) hit = k;
            end
            if (hit >= 0) begin
                n_hits++;
                r.status = STS_OK;
                if (refs[hit] == CNT_MAX)
                    r.status = STS_SAT;
                else
                    refs[hit]++;
                r.need_fill   = !filled[hit];
                filled[hit]   = 1'b1;
                r.entry_index = IDX_W'(hit);
                r.ref_count   = refs[hit];
                return r;
            end
            // Miss: reuse in the own bucket, or else steal from buckets 0 upward.
            e = oldest_free(id);
            if (e < 0) begin
                for (int unsigned b = 0; b < NBKT; b++) begin
                    if (b == id) continue;
                    e = oldest_free(b);
                    if (e >= 0) begin
                        n_steals++;
                        bucket[e]  = BKT_W'(id);
                        stamp[e]   = next_stamp;
                        next_stamp = next_stamp + 1;
                        break;
                    end
                end
            end
            if (e < 0) begin
                r.status = STS_NOBUF;
                return r;
            end
            dev_tag[e]    = dev;
            blk_tag[e]    = blk;
            refs[e]       = 1;
            filled[e]     = 1'b1;
            r.entry_index = IDX_W'(e);
            r.need_fill   = 1'b1;
            r.status      = STS_OK;
            r.ref_count   = 1;
            return r;
        endfunction

        function t_result apply_request(t_kind kind, logic [DEV_W-1:0] dev,
                                        logic [BLK_W-1:0] blk, logic [HDL_W-1:0] hdl);
            t_result r;
            r = '0;
            if (kind == K_GET) return lookup_block(dev, blk);
            r.entry_index = IDX_W'(hdl);
            if (hdl >= NBUF) begin
                r.status = STS_NOBUF;
                return r;
            end
            r.status = STS_OK;
            if (kind == K_PIN) begin
                if (refs[hdl] == CNT_MAX)
                    r.status = STS_SAT;
                else
                    refs[hdl]++;
            end else begin
                if (refs[hdl] == 0)
                    r.status = STS_UNDER;
                else
                    refs[hdl]--;
            end
            r.ref_count = refs[hdl];
            return r;
        endfunction

        // Called for every request item accepted by the block.
        function void note_request(logic [S_USER_W-1:0] user, logic [S_DATA_W-1:0] data);
            t_result r;
            r = apply_request(t_kind'(user), data[7:0], data[39:8], data[44:40]);
            if (t_kind'(user) == K_GET) last_index = r.entry_index;
            expected_q.push_back(r);
        endfunction

        // Called for every result item accepted from the block.
        function void check_result(logic [M_DATA_W-1:0] data);
            t_result got;
            t_result want;
            got = t_result'(data);
            if (expected_q.size() == 0) begin
                $error("result item 0x%04h arrived with nothing expected", data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            n_status[want.status]++;
            if (got.entry_index !== want.entry_index) begin
                $error("entry_index mismatch: expected %0d, actual %0d",
                       want.entry_index, got.entry_index);
                errors++;
            end
            if (got.need_fill !== want.need_fill) begin
                $error("need_fill mismatch: expected %0d, actual %0d",
                       want.need_fill, got.need_fill);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d",
                       want.status, got.status);
                errors++;
            end
            if (got.ref_count !== want.ref_count) begin
                $error("ref_count mismatch: expected %0d, actual %0d",
                       want.ref_count, got.ref_count);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 60;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // device[7:0], block_number[39:8], buffer_handle[44:40], zero[47:45]
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    // kind[1:0]
    logic [S_USER_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // entry_index[4:0], need_fill[5], status[7:6], ref_count[15:8]
    logic [M_DATA_W-1:0]  m_tdata;

    cache_scoreboard sb = new();

    bit tx_idle_on        = 1'b1;
    bit rx_stall_on       = 1'b1;
    bit long_hold_pending = 1'b0;
    int cycle_count       = 0;

    logic [BLK_W-1:0] blk_pool [16];
    logic [DEV_W-1:0] dev_pool [4];

    hashed_block_buffer_cache #(
        .NUM_BUFFERS (DEF_NUM_BUFFERS),
        .NUM_BUCKETS (DEF_NUM_BUCKETS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk) cycle_count++;
        $display("[hashed_block_buffer_cache] ERROR");
        $finish;
    end

    // Monitor both handshakes and feed the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Offer one request item and wait until the block takes it.
    task automatic send_request(t_kind kind, logic [DEV_W-1:0] dev,
                                logic [BLK_W-1:0] blk, logic [HDL_W-1:0] hdl);
        if (tx_idle_on && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, hdl, blk, dev};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_handle_op(t_kind kind);
        int h;
        h = sb.pick_held();
        if (h < 0 || $urandom_range(0, 4) == 0) h = $urandom_range(0, 31);
        send_request(kind, 8'($urandom()), $urandom(), HDL_W'(h));
    endtask

    // Main sequence.
    initial begin
        int h;
        int r;
        logic [BLK_W-1:0] blk;
        logic [DEV_W-1:0] dev;

        blk_pool[0] = 32'h0000_0000;
        blk_pool[1] = 32'h0000_000D;
        blk_pool[2] = 32'h0000_001A;
        blk_pool[3] = 32'hFFFF_FFFF;
        blk_pool[4] = 32'h8000_0000;
        for (int k = 5; k < 16; k++) blk_pool[k] = $urandom();
        dev_pool[0] = 8'h00;
        dev_pool[1] = 8'h01;
        dev_pool[2] = 8'h80;
        dev_pool[3] = 8'hFF;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening. After reset every entry matches device 0 block 0,
        // so the first get hits the newest of them and must be filled.
        send_request(K_GET, 8'h00, 32'h0000_0000, '0);
        send_request(K_GET, 8'h00, 32'h0000_0000, '0);
        send_request(K_RELEASE, '0, '0, 5'd31);
        send_request(K_UNPIN, '0, '0, 5'd31);
        send_request(K_RELEASE, '0, '0, 5'd31);
        send_request(K_UNPIN, '0, '0, 5'd0);
        send_request(K_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_request(K_GET, 8'h55, 32'hAAAA_AAAA, 5'd10);
        send_request(K_GET, 8'hAA, 32'h5555_5555, 5'd21);
        send_request(K_GET, 8'h00, 32'h0000_000D, '0);
        send_request(K_GET, 8'hFF, 32'hFFFF_FFFF, '0);
        send_request(K_PIN, '0, '0, 5'd0);
        send_request(K_PIN, '0, '0, 5'h1F);
        send_request(K_PIN, '0, '0, 5'h15);
        send_request(K_UNPIN, '0, '0, 5'h0A);
        send_request(K_RELEASE, '0, '0, 5'h1F);
        send_request(K_GET, 8'h00, 32'h0000_0000, '0);
        send_request(K_GET, 8'h80, 32'h8000_0000, '0);
        wait_results();

        // Drive one entry's count to the ceiling: pins and a hit saturate.
        send_request(K_GET, 8'h3C, 32'h0F0F_0F0F, '0);
        wait_results();
        h = sb.last_index;
        for (int i = 0; i < 256; i++) send_request(K_PIN, '0, '0, HDL_W'(h));
        send_request(K_GET, 8'h3C, 32'h0F0F_0F0F, '0);
        send_request(K_UNPIN, '0, '0, HDL_W'(h));
        send_request(K_PIN, '0, '0, HDL_W'(h));
        send_request(K_PIN, '0, '0, HDL_W'(h));

        // Fill the table with fresh blocks until no buffer is left, no idling.
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        for (int i = 0; i < 55; i++) send_request(K_GET, 8'($urandom()), $urandom(), '0);
        wait_results();

        // Long hold-off at the receiver while requests keep coming.
        long_hold_pending = 1'b1;
        for (int i = 0; i < 24; i++) send_handle_op(K_RELEASE);
        wait_results();

        // Random churn with hits, reuse, steals and count changes.
        for (int i = 0; i < 580; i++) begin
            if (i % 120 == 0) begin
                tx_idle_on  = ((i / 120) % 3 != 2);
                rx_stall_on = ((i / 120) % 3 != 1);
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                blk = ($urandom_range(0, 9) < 7) ? blk_pool[$urandom_range(0, 15)] : $urandom();
                dev = ($urandom_range(0, 3) != 0) ? dev_pool[$urandom_range(0, 3)]
                                                  : 8'($urandom());
                send_request(K_GET, dev, blk, 5'($urandom()));
            end else if (r < 65) begin
                send_handle_op(K_RELEASE);
            end else if (r < 80) begin
                send_handle_op(K_UNPIN);
            end else if (r < 95) begin
                send_handle_op(K_PIN);
            end else begin
                send_request(t_kind'($urandom_range(0, 3)), 8'($urandom()), $urandom(),
                             5'($urandom()));
            end
        end
        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d ok, %0d no buffer, %0d underflow, %0d saturated.",
                 sb.n_checked, sb.n_status[STS_OK], sb.n_status[STS_NOBUF],
                 sb.n_status[STS_UNDER], sb.n_status[STS_SAT]);
        $display("Gets hit %0d times and stole %0d entries from other buckets.",
                 sb.n_hits, sb.n_steals);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[hashed_block_buffer_cache] OK");
        end else begin
            $display("[hashed_block_buffer_cache] ERROR");
        end
        $finish;
    end

endmodule
